FILE: src/superfasthash_stream_macros.svh
// Assertion macros used by the checker file.
`ifndef SUPERFASTHASH_STREAM_MACROS_SVH
`define SUPERFASTHASH_STREAM_MACROS_SVH

// Implication checked on every edge outside reset.
`define SHS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication checked on every edge, reset included.
`define SHS_ASSERT_ALWAYS(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

FILE: src/shs_pkg.sv
package shs_pkg;

  localparam int unsigned HASH_W  = 32;
  localparam int unsigned COUNT_W = 3;

  // Byte counts that select a mix.
  localparam logic [COUNT_W-1:0] BYTES_FULL  = 3'd4;
  localparam logic [COUNT_W-1:0] BYTES_THREE = 3'd3;
  localparam logic [COUNT_W-1:0] BYTES_TWO   = 3'd2;
  localparam logic [COUNT_W-1:0] BYTES_ONE   = 3'd1;

  // Handoff from the mix stage to the avalanche stages.
  typedef struct packed {
    logic              valid;
    logic [HASH_W-1:0] hash;
  } shs_fin_t;

endpackage

FILE: src/shs_word_if.sv
interface shs_word_if import shs_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [31:0]        data_word;
  logic [COUNT_W-1:0] byte_count;
  logic               last;

  modport source (output valid, data_word, byte_count, last, input ready);
  modport sink (input valid, data_word, byte_count, last, output ready);
endinterface

FILE: src/shs_hash_if.sv
interface shs_hash_if import shs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HASH_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

FILE: src/shs_mix.sv
module shs_mix import shs_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        data_word,
  input  logic [COUNT_W-1:0] byte_count,
  input  logic               last,
  output shs_fin_t           fin,
  input  logic               fin_ready
);

  logic               word_valid;
  logic [31:0]        word;
  logic [COUNT_W-1:0] count;
  logic               word_last;
  logic [HASH_W-1:0]  running_hash;
  logic [HASH_W-1:0]  running_hash_next;
  logic [COUNT_W-1:0] eff_count;
  logic [HASH_W-1:0]  mixed;
  logic               fin_room;
  logic               fire;
  logic               fin_valid;
  logic [HASH_W-1:0]  fin_hash;

  logic [HASH_W-1:0] f1, f2, f3;
  logic [HASH_W-1:0] t1, t2, t3, t4;
  logic [HASH_W-1:0] odd3, odd1;

  assign fin      = '{valid: fin_valid, hash: fin_hash};
  assign fin_room = !fin_valid || fin_ready;
  // A word that is not last never produces a result, so it never waits.
  assign fire     = word_valid && (!word_last || fin_room);
  assign in_ready = !word_valid || fire;

  assign eff_count = (!word_last || count > BYTES_FULL) ? BYTES_FULL : count;
  assign odd3      = {{24{word[23]}}, word[23:16]};
  assign odd1      = {{24{word[7]}}, word[7:0]};

  always_comb begin
    f1 = running_hash + {16'd0, word[15:0]};
    f2 = (f1 << 16) ^ ({5'd0, word[31:16], 11'd0} ^ f1);
    f3 = f2 + (f2 >> 11);
    t1 = '0;
    t2 = '0;
    t3 = '0;
    t4 = '0;
    case (eff_count)
      BYTES_FULL: begin
        mixed = f3;
      end
      BYTES_THREE: begin
        t1 = running_hash + {16'd0, word[15:0]};
        t2 = t1 ^ (t1 << 16);
        t3 = t2 ^ (odd3 << 18);
        t4 = t3 + (t3 >> 11);
        mixed = t4;
      end
      BYTES_TWO: begin
        t1 = running_hash + {16'd0, word[15:0]};
        t2 = t1 ^ (t1 << 11);
        t3 = t2 + (t2 >> 17);
        mixed = t3;
      end
      BYTES_ONE: begin
        t1 = running_hash + odd1;
        t2 = t1 ^ (t1 << 10);
        t3 = t2 + (t2 >> 1);
        mixed = t3;
      end
      default: begin
        mixed = running_hash;
      end
    endcase
    running_hash_next = word_last ? '0 : mixed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      word_valid   <= 1'b0;
      running_hash <= '0;
      fin_valid    <= 1'b0;
    end else begin
      if (in_ready) begin
        word_valid <= in_valid;
      end
      if (fire) begin
        running_hash <= running_hash_next;
      end
      if (fin_room) begin
        fin_valid <= fire && word_last;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word      <= data_word;
      count     <= byte_count;
      word_last <= last;
    end
    if (fin_room && fire) begin
      fin_hash <= mixed;
    end
  end

endmodule

FILE: src/shs_aval.sv
module shs_aval import shs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  shs_fin_t          fin,
  output logic              fin_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [HASH_W-1:0] hash_value
);

  logic              mid_valid;
  logic [HASH_W-1:0] mid;
  logic              out_room;
  logic              mid_room;
  logic [HASH_W-1:0] a1, a2, a3, b1, b2, b3;

  assign out_room  = !out_valid || out_ready;
  assign mid_room  = !mid_valid || out_room;
  assign fin_ready = mid_room;

  // The avalanche is split three steps per stage.
  always_comb begin
    a1 = fin.hash ^ (fin.hash << 3);
    a2 = a1 + (a1 >> 5);
    a3 = a2 ^ (a2 << 4);
    b1 = mid + (mid >> 17);
    b2 = b1 ^ (b1 << 25);
    b3 = b2 + (b2 >> 6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mid_room) begin
        mid_valid <= fin.valid;
      end
      if (out_room) begin
        out_valid <= mid_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mid_room && fin.valid) begin
      mid <= a3;
    end
    if (out_room && mid_valid) begin
      hash_value <= b3;
    end
  end

endmodule

FILE: src/superfasthash_stream.sv
// SuperFastHash over a stream of 32-bit key words, running hash seeded with
// zero. One word is taken every cycle, unless a last word must wait for room
// in the mix result register; the running hash is updated by the mix stage,
// whose register feeds back into the next word's mix. The hash of a key
// passes the input word, mix result and two avalanche registers, held up only
// while the output is stalled. Back-to-back keys need no gap between them.
module superfasthash_stream import shs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  shs_word_if.sink    words,
  shs_hash_if.source  hashes
);

  shs_fin_t fin;
  logic     fin_ready;

  shs_mix u_mix (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (words.valid),
    .in_ready   (words.ready),
    .data_word  (words.data_word),
    .byte_count (words.byte_count),
    .last       (words.last),
    .fin        (fin),
    .fin_ready  (fin_ready)
  );

  shs_aval u_aval (
    .clk        (clk),
    .rst        (rst),
    .fin        (fin),
    .fin_ready  (fin_ready),
    .out_valid  (hashes.valid),
    .out_ready  (hashes.ready),
    .hash_value (hashes.hash_value)
  );

endmodule

FILE: src/shs_checker.sv
`include "superfasthash_stream_macros.svh"

module shs_checker import shs_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              words_ready,
  input logic              hashes_valid,
  input logic              hashes_ready,
  input logic [HASH_W-1:0] hashes_hash_value
);

  // Input backpressure only comes from a result that is waiting.
  `SHS_ASSERT_IMPLY(a_stall_cause, !words_ready, hashes_valid && !hashes_ready, "input stalled without a waiting result")
  // No result is shown right after reset.
  `SHS_ASSERT_ALWAYS(a_reset_quiet, $past(rst), !hashes_valid, "result valid after reset")
  `SHS_ASSERT_IMPLY(a_valid_hold, $past(hashes_valid && !hashes_ready), hashes_valid, "result dropped while stalled")
  `SHS_ASSERT_IMPLY(a_data_hold, $past(hashes_valid && !hashes_ready), $stable(hashes_hash_value), "result changed while stalled")

endmodule

bind superfasthash_stream shs_checker u_shs_checker (
  .clk               (clk),
  .rst               (rst),
  .words_ready       (words.ready),
  .hashes_valid      (hashes.valid),
  .hashes_ready      (hashes.ready),
  .hashes_hash_value (hashes.hash_value)
);
